@@ sv/adcf_pkg.sv @@
// shared constants for the absolute distance constraint filter
`timescale 1ns / 1ps

package adcf_pkg;

  // payload and register widths
  localparam int DATA_W    = 64;
  localparam int BASE_W    = 32;
  localparam int CFG_IDX_W = 2;

  // signed width of the shift offsets (three bases plus an index, with headroom)
  localparam int OFF_W = 35;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_X_BASE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_BASE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_Z_BASE = 2'd2;

endpackage

@@ sv/abs_distance_constraint_filter_top.sv @@
// arc consistency filter for |X - Y| = Z over bitmask domains
`timescale 1ns / 1ps

// Usage
// - input channel (in_valid_i / in_stall_o) carries one transaction of three
//   domain masks; bit i of a mask stands for the value base + i, bits at or
//   above DOM_SIZE are ignored
// - output channel (out_valid_o / out_stall_i) returns the pruned masks and
//   the failed flag, one transaction per input transaction
// - the user must write the bases over the cfg port while the block is idle; it is not enforced
// - each of the three passes has a setup step and then steps through the
//   DOM_SIZE candidate values, one candidate value per cycle through the shared
//   support test unit (two shifted-mask lanes); a pass that empties its domain
//   ends the item early
// - one item at a time: in_stall_o is high from accept until the result sits
//   in the output register, so the next item can go in once it sits there
// - a stalled receiver holds the result in the output register; a finished
//   item waits in the core while that register is still full
// - reset clears the bases to zero and empties both sides
module abs_distance_constraint_filter_top
  import adcf_pkg::*;
#(
  parameter int DOM_SIZE = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration port
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [BASE_W-1:0]    cfg_data_i,
  // input channel
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [DATA_W-1:0]    x_domain_i,
  input  logic [DATA_W-1:0]    y_domain_i,
  input  logic [DATA_W-1:0]    z_domain_i,
  // output channel
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [DATA_W-1:0]    x_pruned_o,
  output logic [DATA_W-1:0]    y_pruned_o,
  output logic [DATA_W-1:0]    z_pruned_o,
  output logic                 failed_o
);

  localparam int IDX_W = (DOM_SIZE > 1) ? $clog2(DOM_SIZE) : 1;
  localparam logic signed [OFF_W-1:0] DOM_S = OFF_W'(DOM_SIZE);
  localparam logic signed [OFF_W-1:0] DOM_M1 = OFF_W'(DOM_SIZE - 1);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DOM_SIZE - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SETUP,
    S_RUN,
    S_WRITE
  } state_e;

  typedef enum logic [1:0] {
    P_X,
    P_Y,
    P_Z
  } pass_e;

  // support test: is there a in A and b in B with a = b + s
  function automatic logic sup_test(input logic [DOM_SIZE-1:0] a,
                                    input logic [DOM_SIZE-1:0] b,
                                    input logic signed [OFF_W-1:0] s);
    logic signed [OFF_W-1:0] neg_s;
    logic [IDX_W-1:0]        amt;
    logic                    hit;
    neg_s = -s;
    amt   = '0;
    hit   = 1'b0;
    if (!s[OFF_W-1]) begin
      if (s < DOM_S) begin
        amt = s[IDX_W-1:0];
        hit = |((a >> amt) & b);
      end
    end else if (neg_s < DOM_S) begin
      amt = neg_s[IDX_W-1:0];
      hit = |((b >> amt) & a);
    end
    return hit;
  endfunction

  state_e state_q;
  pass_e  pass_q;

  logic [BASE_W-1:0] x_base_q, y_base_q, z_base_q;

  logic [DOM_SIZE-1:0] xd_q, yd_q, zd_q, zp_q, keep_q;
  logic [IDX_W-1:0]    idx_q;
  logic signed [OFF_W-1:0] off_a_q, off_b_q;
  logic                failed_q;

  logic                out_valid_q;
  logic [DATA_W-1:0]   x_pruned_q, y_pruned_q, z_pruned_q;
  logic                failed_out_q;

  logic in_accept, out_free;

  logic signed [OFF_W-1:0] xw, yw, zw, neg_zw;
  logic signed [OFF_W-1:0] off_a_d, off_b_d;
  logic [DOM_SIZE-1:0] xd_in, yd_in, zd_in, zp_in;
  logic [DOM_SIZE-1:0] zr, cand, orig, a_a, b_a, a_b, b_b, keep_d;
  logic                hit_a, hit_b, last_idx, pass_fail;

  assign in_accept  = in_valid_i && (state_q == S_IDLE);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE);

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_base_q <= '0;
      y_base_q <= '0;
      z_base_q <= '0;
    end else if (cfg_we_i) begin
      if (cfg_index_i == CFG_X_BASE) x_base_q <= cfg_data_i;
      if (cfg_index_i == CFG_Y_BASE) y_base_q <= cfg_data_i;
      if (cfg_index_i == CFG_Z_BASE) z_base_q <= cfg_data_i;
    end
  end

  // sign-extended bases
  assign xw     = OFF_W'($signed(x_base_q));
  assign yw     = OFF_W'($signed(y_base_q));
  assign zw     = OFF_W'($signed(z_base_q));
  assign neg_zw = -zw;

  // incoming masks and the mask of non-negative distances
  always_comb begin
    xd_in = x_domain_i[DOM_SIZE-1:0];
    yd_in = y_domain_i[DOM_SIZE-1:0];
    zd_in = z_domain_i[DOM_SIZE-1:0];
    if (!zw[OFF_W-1]) begin
      zp_in = zd_in;
    end else if (neg_zw >= DOM_S) begin
      zp_in = '0;
    end else begin
      zp_in = zd_in & ({DOM_SIZE{1'b1}} << neg_zw[IDX_W-1:0]);
    end
  end

  // reversed distance mask for the sum lane
  always_comb begin
    for (int m = 0; m < DOM_SIZE; m++) begin
      zr[m] = zp_q[DOM_SIZE-1-m];
    end
  end

  // operand selection per pass
  always_comb begin
    unique case (pass_q)
      P_X: begin
        cand = xd_q;
        orig = xd_q;
        a_a  = yd_q;
        b_a  = zp_q;
        a_b  = yd_q;
        b_b  = zr;
      end
      P_Y: begin
        cand = yd_q;
        orig = yd_q;
        a_a  = xd_q;
        b_a  = zp_q;
        a_b  = xd_q;
        b_b  = zr;
      end
      default: begin
        cand = zp_q;
        orig = zd_q;
        a_a  = xd_q;
        b_a  = yd_q;
        a_b  = yd_q;
        b_b  = xd_q;
      end
    endcase
  end

  // starting offsets of the two lanes for each pass
  always_comb begin
    unique case (pass_q)
      P_X: begin
        off_a_d = xw + zw - yw;
        off_b_d = xw - zw - yw - DOM_M1;
      end
      P_Y: begin
        off_a_d = yw + zw - xw;
        off_b_d = yw - zw - xw - DOM_M1;
      end
      default: begin
        off_a_d = yw + zw - xw;
        off_b_d = xw + zw - yw;
      end
    endcase
  end

  // shared support test for the current candidate
  always_comb begin
    hit_a          = sup_test(a_a, b_a, off_a_q);
    hit_b          = sup_test(a_b, b_b, off_b_q);
    keep_d         = keep_q;
    keep_d[idx_q]  = cand[idx_q] & (hit_a | hit_b);
    last_idx       = (idx_q == IDX_LAST);
    pass_fail      = (orig != '0) && (keep_d == '0);
  end

  // sequencer and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      pass_q       <= P_X;
      out_valid_q  <= 1'b0;
      failed_q     <= 1'b0;
      idx_q        <= '0;
      xd_q         <= '0;
      yd_q         <= '0;
      zd_q         <= '0;
      zp_q         <= '0;
      keep_q       <= '0;
      off_a_q      <= '0;
      off_b_q      <= '0;
      x_pruned_q   <= '0;
      y_pruned_q   <= '0;
      z_pruned_q   <= '0;
      failed_out_q <= 1'b0;
    end else begin
      // drop the result once taken, unless a new one is loaded this cycle
      if (out_valid_q && !out_stall_i && (state_q != S_WRITE)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_accept) begin
            xd_q     <= xd_in;
            yd_q     <= yd_in;
            zd_q     <= zd_in;
            zp_q     <= zp_in;
            failed_q <= 1'b0;
            pass_q   <= P_X;
            state_q  <= S_SETUP;
          end
        end
        S_SETUP: begin
          off_a_q <= off_a_d;
          off_b_q <= off_b_d;
          idx_q   <= '0;
          keep_q  <= '0;
          state_q <= S_RUN;
        end
        S_RUN: begin
          keep_q  <= keep_d;
          off_a_q <= off_a_q + OFF_W'(1);
          off_b_q <= off_b_q + OFF_W'(1);
          idx_q   <= idx_q + IDX_W'(1);
          if (last_idx) begin
            failed_q <= pass_fail;
            unique case (pass_q)
              P_X: begin
                xd_q    <= keep_d;
                pass_q  <= P_Y;
                state_q <= pass_fail ? S_WRITE : S_SETUP;
              end
              P_Y: begin
                yd_q    <= keep_d;
                pass_q  <= P_Z;
                state_q <= pass_fail ? S_WRITE : S_SETUP;
              end
              default: begin
                zd_q    <= keep_d;
                state_q <= S_WRITE;
              end
            endcase
          end
        end
        default: begin
          if (out_free) begin
            x_pruned_q   <= DATA_W'(xd_q);
            y_pruned_q   <= DATA_W'(yd_q);
            z_pruned_q   <= DATA_W'(zd_q);
            failed_out_q <= failed_q;
            out_valid_q  <= 1'b1;
            state_q      <= S_IDLE;
          end
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign x_pruned_o  = x_pruned_q;
  assign y_pruned_o  = y_pruned_q;
  assign z_pruned_o  = z_pruned_q;
  assign failed_o    = failed_out_q;

  // a failing result always carries an empty domain
  a_fail_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && failed_o |->
      (x_pruned_o == '0) || (y_pruned_o == '0) || (z_pruned_o == '0))
    else $error("failed result without an empty domain");

  // an empty X without failure forces empty Y and Z
  a_empty_x_chain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !failed_o && (x_pruned_o == '0) |->
      (y_pruned_o == '0) && (z_pruned_o == '0))
    else $error("empty X passed without emptying Y and Z");

  // kept values are always candidates of the current pass
  a_keep_subset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RUN) |-> ((keep_q & ~cand) == '0))
    else $error("kept value outside the candidate domain");

  // an accepted transaction makes the block busy
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o && (state_q == S_SETUP))
    else $error("block not busy after accepting a transaction");

endmodule

@@ test/tb_top.sv @@
// testbench for the absolute distance constraint filter, checked against a pruning model
`timescale 1ns / 1ps

module tb_top;
  import adcf_pkg::*;

  localparam int DOM_SIZE      = 64;
  localparam int LATENCY       = 3 * (DOM_SIZE + 1) + 1;
  localparam int DRAIN_CYCLES  = LATENCY + 8;
  localparam int LONG_HOLD     = 1500;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_ITEMS   = 60;
  localparam longint TIMEOUT_NS = 4000000;

  // index with no register behind it
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  localparam logic [BASE_W-1:0] BASE_MIN = 32'h8000_0000;
  localparam logic [BASE_W-1:0] BASE_MAX = 32'h7fff_ffff;

  typedef struct {
    logic [DATA_W-1:0] x;
    logic [DATA_W-1:0] y;
    logic [DATA_W-1:0] z;
  } domain_set_t;

  typedef struct {
    logic [DATA_W-1:0] x;
    logic [DATA_W-1:0] y;
    logic [DATA_W-1:0] z;
    logic              failed;
  } pruned_set_t;

  // prunes each accepted domain set and compares with what comes out
  class prune_checker;
    longint      x_base;
    longint      y_base;
    longint      z_base;
    pruned_set_t pruned_q[$];
    int          errors;
    int          n_checked;
    int          n_flagged;

    function new();
      x_base = 0;
      y_base = 0;
      z_base = 0;
      errors = 0;
      n_checked = 0;
      n_flagged = 0;
    endfunction

    function void report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [BASE_W-1:0] data);
      case (idx)
        CFG_X_BASE: x_base = longint'(signed'(data));
        CFG_Y_BASE: y_base = longint'(signed'(data));
        CFG_Z_BASE: z_base = longint'(signed'(data));
        default: ;
      endcase
    endfunction

    // value v lies inside the window of a domain and its bit is set
    function bit contains(logic [DATA_W-1:0] mask, longint base, longint v);
      longint off;
      off = v - base;
      if (off < 0 || off >= DOM_SIZE) return 1'b0;
      return mask[off];
    endfunction

    // keep a value of A if some value of B puts the distance into C
    function logic [DATA_W-1:0] prune_side(logic [DATA_W-1:0] a_dom, longint a_b,
                                           logic [DATA_W-1:0] b_dom, longint b_b,
                                           logic [DATA_W-1:0] c_dom, longint c_b);
      logic [DATA_W-1:0] keep;
      longint va;
      longint d;
      keep = '0;
      for (int i = 0; i < DOM_SIZE; i++) begin
        if (a_dom[i]) begin
          va = a_b + i;
          for (int j = 0; j < DOM_SIZE; j++) begin
            if (b_dom[j]) begin
              d = va - (b_b + j);
              if (d < 0) d = -d;
              if (contains(c_dom, c_b, d)) begin
                keep[i] = 1'b1;
                break;
              end
            end
          end
        end
      end
      return keep;
    endfunction

    // keep a distance if some x has a y at that distance on either side
    function logic [DATA_W-1:0] prune_dist(logic [DATA_W-1:0] xd, logic [DATA_W-1:0] yd,
                                           logic [DATA_W-1:0] zd);
      logic [DATA_W-1:0] keep;
      longint vz;
      longint vx;
      keep = '0;
      for (int k = 0; k < DOM_SIZE; k++) begin
        vz = z_base + k;
        if (zd[k] && vz >= 0) begin
          for (int i = 0; i < DOM_SIZE; i++) begin
            if (xd[i]) begin
              vx = x_base + i;
              if (contains(yd, y_base, vx - vz) || contains(yd, y_base, vx + vz)) begin
                keep[k] = 1'b1;
                break;
              end
            end
          end
        end
      end
      return keep;
    endfunction

    function pruned_set_t prune_domains(domain_set_t s);
      pruned_set_t       r;
      logic [DATA_W-1:0] dmask;
      logic [DATA_W-1:0] nd;
      dmask = {DATA_W{1'b1}} >> (DATA_W - DOM_SIZE);
      r.x = s.x & dmask;
      r.y = s.y & dmask;
      r.z = s.z & dmask;
      r.failed = 1'b0;
      // pass one: x against y and z
      nd = prune_side(r.x, x_base, r.y, y_base, r.z, z_base);
      if (r.x != '0 && nd == '0) r.failed = 1'b1;
      r.x = nd;
      // pass two: y against the pruned x
      if (!r.failed) begin
        nd = prune_side(r.y, y_base, r.x, x_base, r.z, z_base);
        if (r.y != '0 && nd == '0) r.failed = 1'b1;
        r.y = nd;
      end
      // pass three: distances against both pruned sides
      if (!r.failed) begin
        nd = prune_dist(r.x, r.y, r.z);
        if (r.z != '0 && nd == '0) r.failed = 1'b1;
        r.z = nd;
      end
      return r;
    endfunction

    function void note_input(domain_set_t s);
      pruned_q.push_back(prune_domains(s));
    endfunction

    function void check_result(pruned_set_t got);
      pruned_set_t want;
      if (pruned_q.size() == 0) begin
        report($sformatf("result with no transaction waiting: x %h y %h z %h failed %0b",
                         got.x, got.y, got.z, got.failed));
        return;
      end
      want = pruned_q.pop_front();
      n_checked++;
      if (want.failed) n_flagged++;
      if (got.x !== want.x)
        report($sformatf("x_pruned %h, expected %h", got.x, want.x));
      if (got.y !== want.y)
        report($sformatf("y_pruned %h, expected %h", got.y, want.y));
      if (got.z !== want.z)
        report($sformatf("z_pruned %h, expected %h", got.z, want.z));
      if (got.failed !== want.failed)
        report($sformatf("failed %b, expected %b", got.failed, want.failed));
    endfunction

    function int pending();
      return pruned_q.size();
    endfunction
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [BASE_W-1:0]    cfg_data_i = '0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  logic [DATA_W-1:0]    x_domain_i = '0;
  logic [DATA_W-1:0]    y_domain_i = '0;
  logic [DATA_W-1:0]    z_domain_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic [DATA_W-1:0]    x_pruned_o;
  logic [DATA_W-1:0]    y_pruned_o;
  logic [DATA_W-1:0]    z_pruned_o;
  logic                 failed_o;

  prune_checker sb;
  domain_set_t  item_q[$];
  bit           long_hold_req = 1'b0;
  int           n_accepted = 0;
  int           n_settings = 0;

  abs_distance_constraint_filter_top #(
    .DOM_SIZE(DOM_SIZE)
  ) u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .x_domain_i  (x_domain_i),
    .y_domain_i  (y_domain_i),
    .z_domain_i  (z_domain_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .x_pruned_o  (x_pruned_o),
    .y_pruned_o  (y_pruned_o),
    .z_pruned_o  (z_pruned_o),
    .failed_o    (failed_o)
  );

  // clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // run limit
  initial begin
    #(TIMEOUT_NS);
    $display("simulation failed");
    $finish;
  end

  // receiver: checks results, stalls on its own pattern with one long hold-off
  initial begin : receiver
    pruned_set_t got;
    int          mode;
    int          mode_left;
    int          run_left;
    int          hold_left;
    logic        stall_next;
    mode = 0;
    mode_left = 0;
    run_left = 0;
    hold_left = 0;
    stall_next = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        got.x = x_pruned_o;
        got.y = y_pruned_o;
        got.z = z_pruned_o;
        got.failed = failed_o;
        sb.check_result(got);
      end
      if (hold_left > 0) begin
        hold_left--;
        stall_next = 1'b1;
      end else if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left = LONG_HOLD;
        stall_next = 1'b1;
      end else begin
        if (mode_left == 0) begin
          mode = $urandom_range(0, 2);
          mode_left = $urandom_range(50, 600);
        end
        mode_left--;
        case (mode)
          0: stall_next = 1'b0;
          1: stall_next = $urandom_range(0, 1);
          default: begin
            if (run_left == 0) begin
              stall_next = ~stall_next;
              run_left = $urandom_range(1, 250);
            end
            run_left--;
          end
        endcase
      end
      out_stall_i <= stall_next;
    end
  end

  // sender: offers queued transactions in bursts with random gaps
  task automatic drive_items();
    domain_set_t cur;
    bit          busy;
    int          gap;
    int          burst;
    busy = 1'b0;
    gap = 0;
    burst = $urandom_range(1, 8);
    while (item_q.size() > 0 || busy) begin
      @(posedge clk_i);
      if (busy && in_valid_i && !in_stall_o) begin
        sb.note_input(cur);
        n_accepted++;
        busy = 1'b0;
      end
      if (!busy && item_q.size() > 0) begin
        if (gap > 0) begin
          gap--;
        end else begin
          cur = item_q.pop_front();
          busy = 1'b1;
          burst--;
          if (burst == 0) begin
            burst = $urandom_range(1, 8);
            gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 300);
          end
        end
      end
      in_valid_i <= busy;
      if (busy) begin
        x_domain_i <= cur.x;
        y_domain_i <= cur.y;
        z_domain_i <= cur.z;
      end
    end
  endtask

  task automatic wait_drained();
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BASE_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    sb.write_reg(idx, data);
  endtask

  task automatic set_bases(input logic [BASE_W-1:0] xb, input logic [BASE_W-1:0] yb,
                           input logic [BASE_W-1:0] zb);
    write_reg(CFG_X_BASE, xb);
    write_reg(CFG_Y_BASE, yb);
    write_reg(CFG_Z_BASE, zb);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    n_settings++;
  endtask

  function automatic void add(logic [DATA_W-1:0] x, logic [DATA_W-1:0] y,
                              logic [DATA_W-1:0] z);
    domain_set_t s;
    s.x = x;
    s.y = y;
    s.z = z;
    item_q.push_back(s);
  endfunction

  // mask of a random shape: random, dense, sparse, a few bits, a window, empty, full ones
  function automatic logic [DATA_W-1:0] rand_mask();
    logic [DATA_W-1:0] m;
    int                pick;
    int                lo;
    int                hi;
    pick = $urandom_range(0, 99);
    m = '0;
    if (pick < 25) begin
      m = {$urandom, $urandom};
    end else if (pick < 40) begin
      m = {$urandom, $urandom} | {$urandom, $urandom};
    end else if (pick < 65) begin
      m = {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
    end else if (pick < 85) begin
      repeat ($urandom_range(1, 4)) m[$urandom_range(0, DOM_SIZE - 1)] = 1'b1;
    end else if (pick < 93) begin
      lo = $urandom_range(0, DOM_SIZE - 1);
      hi = $urandom_range(lo, DOM_SIZE - 1);
      for (int i = lo; i <= hi; i++) m[i] = 1'b1;
    end else if (pick >= 97) begin
      m = '1;
    end
    return m;
  endfunction

  // x/y pairs with their distance planted in z, plus some noise bits
  function automatic domain_set_t planted_item();
    domain_set_t s;
    int          xi;
    int          yj;
    longint      d;
    longint      kz;
    s.x = '0;
    s.y = '0;
    s.z = '0;
    repeat ($urandom_range(1, 4)) begin
      xi = $urandom_range(0, DOM_SIZE - 1);
      yj = $urandom_range(0, DOM_SIZE - 1);
      d = (sb.x_base + xi) - (sb.y_base + yj);
      if (d < 0) d = -d;
      kz = d - sb.z_base;
      s.x[xi] = 1'b1;
      s.y[yj] = 1'b1;
      if (kz >= 0 && kz < DOM_SIZE) s.z[kz] = 1'b1;
    end
    if ($urandom_range(0, 1)) s.x |= rand_mask() & rand_mask();
    if ($urandom_range(0, 1)) s.y |= rand_mask() & rand_mask();
    if ($urandom_range(0, 1)) s.z |= rand_mask() & rand_mask();
    return s;
  endfunction

  task automatic random_phase(input int n);
    domain_set_t s;
    repeat (n) begin
      if ($urandom_range(0, 9) < 6) begin
        s = planted_item();
      end else begin
        s.x = rand_mask();
        s.y = rand_mask();
        s.z = rand_mask();
      end
      item_q.push_back(s);
    end
    drive_items();
    wait_drained();
  endtask

  initial begin : main
    logic [BASE_W-1:0] b;
    sb = new();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // directed, reset bases: empty domains, full domains, single-bit supports
    add('0, '0, '0);
    add('1, '1, '1);
    add('0, '1, '1);
    add('1, '0, '1);
    add('1, '1, '0);
    add(64'h8000_0000_0000_0000, 64'h1, 64'h8000_0000_0000_0000);
    add(64'h8000_0000_0000_0000, 64'h1, 64'h4000_0000_0000_0000);
    add(64'h21, 64'h8, 64'h0000_0100_0000_000c);
    add(64'h400, 64'h0010_0400, 64'h1);
    add({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom});
    drive_items();
    wait_drained();

    // directed, negative distances and values outside the windows
    set_bases(-32'sd4, 32'd0, -32'sd8);
    add('1, '1, 64'hff);
    add('1, '1, '1);
    add(64'h1, 64'h8000_0000_0000_0000, '1);
    add('1, 64'h1, 64'h100);
    add(64'hf0, 64'h0f, 64'h0000_0000_00ff_ff00);
    drive_items();
    wait_drained();

    // directed, extreme bases far apart
    set_bases(BASE_MIN, BASE_MAX, BASE_MAX);
    add('1, '1, '1);
    add('0, '0, '0);
    add('0, '1, '0);
    drive_items();
    wait_drained();

    // directed, top of the value range with every distance negative, then at zero
    set_bases(BASE_MAX, BASE_MAX, BASE_MIN);
    add('1, '1, '1);
    add('1, '1, '0);
    drive_items();
    wait_drained();
    set_bases(BASE_MAX, BASE_MAX, 32'd0);
    add('1, '1, '1);
    add(64'h8000_0000_0000_0001, 64'h8000_0000_0000_0000, 64'h8000_0000_0000_0001);
    drive_items();
    wait_drained();

    // random phases over several base settings
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: set_bases(32'd0, 32'd0, 32'd0);
        1: set_bases(-32'sd10, 32'd5, -32'sd6);
        2: set_bases(BASE_MIN, BASE_MIN, -32'sd20);
        3: set_bases(BASE_MAX, BASE_MAX - 32'd40, 32'd0);
        4: set_bases(BASE_MIN, BASE_MAX, BASE_MIN);
        5: set_bases(32'd30, -32'sd30, 32'd10);
        default: begin
          b = $urandom;
          set_bases(b, b + $urandom_range(0, 120) - 60, $urandom_range(0, 80) - 40);
        end
      endcase
      // a write to the unused index must leave the bases alone
      if (p == 1) begin
        write_reg(CFG_UNUSED, $urandom);
        @(posedge clk_i);
        cfg_we_i <= 1'b0;
      end
      if (p == 2) long_hold_req = 1'b1;
      random_phase(PHASE_ITEMS);
    end

    $display("%0d transactions accepted and %0d results checked over %0d base settings",
             n_accepted, sb.n_checked, n_settings);
    $display("%0d results reported a domain wiped out by a pass", sb.n_flagged);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
